/* rtl/core/bsp_pkg.sv */
// Shared constants, types and packet byte positions for the servo packet framer.
package bsp_pkg;

	localparam logic [7:0]  HDR_BYTE      = 8'h55;
	localparam logic [7:0]  OPC_MOVE      = 8'h01;
	localparam logic [7:0]  OPC_TORQUE    = 8'h1F;
	localparam logic [7:0]  TORQUE_PARAM  = 8'h01;
	localparam logic [7:0]  LEN_MOVE      = 8'd7;
	localparam logic [7:0]  LEN_TORQUE    = 8'd4;
	localparam logic [15:0] MOVE_TIME_RST = 16'h0064;

	localparam logic FUNC_MOVE   = 1'b0;
	localparam logic FUNC_TORQUE = 1'b1;

	localparam int ANGLE_W  = 14;
	localparam int ANG_C_W  = 12;
	localparam logic [ANG_C_W-1:0] ANGLE_MAX = 12'd3840;

	// pos = floor(ang * 25 / 96) as ang * ceil(2^20 * 25 / 96) >> 20, exact on 0..3840
	localparam int POS_W     = 10;
	localparam int POS_SHIFT = 20;
	localparam int MUL_W     = 19;
	localparam int PROD_W    = 31;
	localparam logic [MUL_W-1:0] POS_MUL = 19'd273067;

	// byte positions within a packet
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] BI_HDR0 = 4'd0;
	localparam logic [IDX_W-1:0] BI_HDR1 = 4'd1;
	localparam logic [IDX_W-1:0] BI_ID   = 4'd2;
	localparam logic [IDX_W-1:0] BI_LEN  = 4'd3;
	localparam logic [IDX_W-1:0] BI_CMD  = 4'd4;
	localparam logic [IDX_W-1:0] BI_P0   = 4'd5;
	localparam logic [IDX_W-1:0] BI_P1   = 4'd6;
	localparam logic [IDX_W-1:0] BI_P2   = 4'd7;
	localparam logic [IDX_W-1:0] BI_P3   = 4'd8;
	localparam logic [IDX_W-1:0] BI_P4   = 4'd9;
	localparam logic [IDX_W-1:0] LAST_MOVE   = 4'd9;
	localparam logic [IDX_W-1:0] LAST_TORQUE = 4'd6;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	typedef struct packed {
		logic             func;
		logic [7:0]       id;
		logic [POS_W-1:0] pos;
	} cmd_t;

endpackage

/* rtl/core/bsp_front.sv */
// Front end: accepts commands, clamps and scales the angle, hands entries to the queue.
module bsp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         func,
	input  logic [7:0]                   servo_id,
	input  logic signed [bsp_pkg::ANGLE_W-1:0] angle,
	output logic                         q_wr,
	output bsp_pkg::cmd_t                q_wdata,
	input  logic                         q_full
);

	logic                          valid_s1;
	logic                          func_s1;
	logic [7:0]                    id_s1;
	logic [bsp_pkg::POS_W-1:0]     pos_s1;
	logic [bsp_pkg::ANG_C_W-1:0]   ang_c;
	logic [bsp_pkg::PROD_W-1:0]    prod;
	logic                          accept;

	always_comb begin
		if (angle[bsp_pkg::ANGLE_W-1]) begin
			ang_c = '0;
		end else if (angle[bsp_pkg::ANGLE_W-2:0] >
				{1'b0, bsp_pkg::ANGLE_MAX}) begin
			ang_c = bsp_pkg::ANGLE_MAX;
		end else begin
			ang_c = angle[bsp_pkg::ANG_C_W-1:0];
		end
	end

	assign prod   = bsp_pkg::PROD_W'(ang_c) * bsp_pkg::PROD_W'(bsp_pkg::POS_MUL);
	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = valid_s1 && !q_full;

	always_comb begin
		q_wdata.func = func_s1;
		q_wdata.id   = id_s1;
		q_wdata.pos  = pos_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			id_s1   <= servo_id;
			pos_s1  <= prod[bsp_pkg::POS_SHIFT +: bsp_pkg::POS_W];
		end
	end

endmodule

/* rtl/core/bsp_cmd_fifo.sv */
// Short command queue between front end and packet emitter.
module bsp_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  bsp_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output bsp_pkg::cmd_t rdata,
	output logic          nonempty
);

	bsp_pkg::cmd_t               mem_q [bsp_pkg::QDEPTH];
	logic [bsp_pkg::QAW-1:0]     wptr_q;
	logic [bsp_pkg::QAW-1:0]     rptr_q;
	logic [bsp_pkg::QCW-1:0]     cnt_q;

	assign full     = cnt_q == bsp_pkg::QCW'(bsp_pkg::QDEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/bsp_back.sv */
// Back end: walks the head command byte by byte into the result register.
module bsp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bsp_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_done,
	input  logic [15:0]   move_time,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    byte_out,
	output logic          last
);

	logic [bsp_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      torque;
	logic [7:0]                len, code, p0, p1, p2, p3, chk, byte_c;
	logic                      last_c;
	logic                      ld;

	assign torque = cmd.func == bsp_pkg::FUNC_TORQUE;

	always_comb begin
		if (torque) begin
			len  = bsp_pkg::LEN_TORQUE;
			code = bsp_pkg::OPC_TORQUE;
			p0   = bsp_pkg::TORQUE_PARAM;
			p1   = '0;
			p2   = '0;
			p3   = '0;
		end else begin
			len  = bsp_pkg::LEN_MOVE;
			code = bsp_pkg::OPC_MOVE;
			p0   = cmd.pos[7:0];
			p1   = 8'(cmd.pos[bsp_pkg::POS_W-1:8]);
			p2   = move_time[7:0];
			p3   = move_time[15:8];
		end
		chk = ~(cmd.id + len + code + p0 + p1 + p2 + p3);
	end

	always_comb begin
		case (idx_q) inside
			bsp_pkg::BI_HDR0, bsp_pkg::BI_HDR1: byte_c = bsp_pkg::HDR_BYTE;
			bsp_pkg::BI_ID:  byte_c = cmd.id;
			bsp_pkg::BI_LEN: byte_c = len;
			bsp_pkg::BI_CMD: byte_c = code;
			bsp_pkg::BI_P0:  byte_c = p0;
			bsp_pkg::BI_P1:  byte_c = torque ? chk : p1;
			bsp_pkg::BI_P2:  byte_c = p2;
			bsp_pkg::BI_P3:  byte_c = p3;
			bsp_pkg::BI_P4:  byte_c = chk;
			default:         byte_c = '0;
		endcase
		last_c = idx_q == (torque ? bsp_pkg::LAST_TORQUE : bsp_pkg::LAST_MOVE);
	end

	// load the next byte of a waiting command whenever the result register is free or being taken
	assign ld       = cmd_valid && (!out_valid_q || pop);
	assign cmd_done = ld && last_c;
	assign empty    = !out_valid_q;
	assign byte_out = byte_q;
	assign last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
			idx_q       <= last_c ? '0 : idx_q + 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			byte_q <= byte_c;
			last_q <= last_c;
		end
	end

endmodule

/* rtl/core/bus_servo_packet_framer.sv */
// Servo packet framer: one command in, one packet of 7 (torque enable) or 10 (move)
// bytes out at one byte per cycle, back to back across packets when pop stays high
// and the next command is queued; the first byte of a packet passes the angle scaling
// stage register, the command queue and the result register after its command is
// accepted, and the sustained rate is set by the byte-per-cycle result register;
// a two-entry command queue lets new commands enter while a packet is still going out.
module bus_servo_packet_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  servo_id,
	input  logic signed [bsp_pkg::ANGLE_W-1:0] angle,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  byte_out,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic          q_wr, q_full, q_rd, q_nonempty;
	bsp_pkg::cmd_t q_wdata, q_rdata;
	logic [15:0]   move_time_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q <= bsp_pkg::MOVE_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			move_time_q <= cfg_data;
		end
	end

	bsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.servo_id (servo_id),
		.angle    (angle),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	bsp_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.full     (q_full),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	bsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_rdata),
		.cmd_valid (q_nonempty),
		.cmd_done  (q_rd),
		.move_time (move_time_q),
		.empty     (empty),
		.pop       (pop),
		.byte_out  (byte_out),
		.last      (last)
	);

endmodule

/* rtl/core/bsp_checker.sv */
// Port-level checks for the servo packet framer, bound to the top level.
module bsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] byte_out,
	input logic       last
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(byte_out) && $stable(last))
		else $error("result changed while waiting");

	// a packet goes out without gaps once started
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> !empty)
		else $error("gap inside packet");

	// after a packet ends the next result is a header byte
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && last |=> empty || byte_out == bsp_pkg::HDR_BYTE)
		else $error("packet does not start with header");

	// the first byte after a packet never carries the end mark
	a_hdr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && last |=> empty || !last)
		else $error("packet shorter than two bytes");

endmodule

bind bus_servo_packet_framer bsp_checker u_bsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.byte_out (byte_out),
	.last     (last)
);
